// File: hdl/mkd_pkg.sv
// Shared types, codes and the character table of the Morse key decoder.
package mkd_pkg;

	// Width of one configuration register and of the register index.
	localparam int CFG_BITS = 8;
	localparam int CFG_INDEX_BITS = 3;

	// Code register: a leading marker bit followed by up to six symbols.
	localparam int CODE_BITS = 7;
	localparam int CHAR_BITS = 7;
	localparam int TABLE_ENTRIES = 64;
	localparam int TABLE_INDEX_BITS = $clog2(TABLE_ENTRIES);

	// Gap marks record which gap action has already fired in this release.
	localparam logic [2:0] MARK_NONE = 3'b000;
	localparam logic [2:0] MARK_SYMBOL = 3'b100;
	localparam logic [2:0] MARK_LETTER = 3'b010;
	localparam logic [2:0] MARK_WORD = 3'b001;

	localparam logic [CODE_BITS-1:0] CODE_START = 7'd1;
	localparam logic SYMBOL_DOT = 1'b0;
	localparam logic SYMBOL_DASH = 1'b1;

	localparam logic [CHAR_BITS-1:0] CHAR_NONE = 7'h00;
	localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 7'h20;
	localparam logic [CHAR_BITS-1:0] CHAR_STAR = 7'h2A;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DIT_MAX = 3'd0,
		REG_DAH_MIN = 3'd1,
		REG_SYMBOL_GAP_MAX = 3'd2,
		REG_LETTER_GAP_MIN = 3'd3,
		REG_WORD_GAP = 3'd4
	} cfg_reg_t;

	localparam logic [CFG_BITS-1:0] DIT_MAX_RESET = 8'd5;
	localparam logic [CFG_BITS-1:0] DAH_MIN_RESET = 8'd15;
	localparam logic [CFG_BITS-1:0] SYMBOL_GAP_MAX_RESET = 8'd5;
	localparam logic [CFG_BITS-1:0] LETTER_GAP_MIN_RESET = 8'd15;
	localparam logic [CFG_BITS-1:0] WORD_GAP_RESET = 8'd35;

	// Timing thresholds, all in sample ticks.
	typedef struct packed {
		logic [CFG_BITS-1:0] dit_max_ticks;
		logic [CFG_BITS-1:0] dah_min_ticks;
		logic [CFG_BITS-1:0] symbol_gap_max_ticks;
		logic [CFG_BITS-1:0] letter_gap_min_ticks;
		logic [CFG_BITS-1:0] word_gap_ticks;
	} cfg_t;

	// Decoder state apart from the two tick counters.
	typedef struct packed {
		logic [CODE_BITS-1:0] code_bits;
		logic last_symbol;
		logic [2:0] gap_marks;
		logic lamp;
	} ctl_t;

	// One result beat.
	typedef struct packed {
		logic lamp_on;
		logic char_valid;
		logic [CHAR_BITS-1:0] char_code;
	} res_t;

	// Character for each code; the first character of the string is entry 0.
	localparam logic [TABLE_ENTRIES*8-1:0] LETTER_TABLE =
		"  ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2**+****16=/*****7***8*90";

	function automatic logic [CHAR_BITS-1:0] letter_char(
		input logic [TABLE_INDEX_BITS-1:0] idx
	);
		logic [7:0] b;
		b = LETTER_TABLE[(TABLE_ENTRIES - 1 - int'(idx)) * 8 +: 8];
		return b[CHAR_BITS-1:0];
	endfunction

endpackage

// File: hdl/mkd_if.sv
// Valid/ready channel interfaces of the Morse key decoder.

// Key sample channel.
interface mkd_key_if;
	logic valid;
	logic ready;
	logic key_pressed;
	modport source(output valid, output key_pressed, input ready);
	modport sink(input valid, input key_pressed, output ready);
endinterface

// Decoded result channel.
interface mkd_res_if;
	logic valid;
	logic ready;
	logic lamp_on;
	logic char_valid;
	logic [6:0] char_code;
	modport source(output valid, output lamp_on, output char_valid, output char_code,
		input ready);
	modport sink(input valid, input lamp_on, input char_valid, input char_code,
		output ready);
endinterface

// Configuration write channel.
interface mkd_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: hdl/mkd_step.sv
// Next-state and result logic for one key sample tick.
module mkd_step
	import mkd_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  logic                  key_pressed,
	input  cfg_t                  cfg,
	input  logic [COUNT_BITS-1:0] press_count,
	input  logic [COUNT_BITS-1:0] release_count,
	input  ctl_t                  ctl,
	output logic [COUNT_BITS-1:0] press_count_next,
	output logic [COUNT_BITS-1:0] release_count_next,
	output ctl_t                  ctl_next,
	output res_t                  res
);

	// Comparisons run at the wider of the counter and register widths.
	localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [CMP_BITS-1:0] pc;
	logic [CMP_BITS-1:0] rc;
	logic [CMP_BITS-1:0] dit;
	logic [CMP_BITS-1:0] dah;
	logic [CMP_BITS-1:0] sgap;
	logic [CMP_BITS-1:0] lgap;
	logic [CMP_BITS-1:0] wgap;
	logic [CMP_BITS-1:0] cmax;

	assign pc = CMP_BITS'(press_count);
	assign rc = CMP_BITS'(release_count);
	assign dit = CMP_BITS'(cfg.dit_max_ticks);
	assign dah = CMP_BITS'(cfg.dah_min_ticks);
	assign sgap = CMP_BITS'(cfg.symbol_gap_max_ticks);
	assign lgap = CMP_BITS'(cfg.letter_gap_min_ticks);
	assign wgap = CMP_BITS'(cfg.word_gap_ticks);
	assign cmax = CMP_BITS'(COUNT_MAX);

	// Increment that saturates at the word gap and at the counter's top value.
	function automatic logic [COUNT_BITS-1:0] bump(
		input logic [CMP_BITS-1:0] c,
		input logic [CMP_BITS-1:0] lim,
		input logic [CMP_BITS-1:0] top
	);
		logic [CMP_BITS:0] n;
		n = {1'b0, c} + (CMP_BITS + 1)'(1);
		if (n > {1'b0, lim}) n = {1'b0, lim};
		if (n > {1'b0, top}) n = {1'b0, top};
		return n[COUNT_BITS-1:0];
	endfunction

	// Classify the stored press, then act on the stored release.
	always_comb begin
		ctl_next = ctl;
		res.char_valid = 1'b0;
		res.char_code = CHAR_NONE;

		if (pc != '0 && pc <= dit) begin
			ctl_next.last_symbol = SYMBOL_DOT;
		end else if (pc >= dah) begin
			ctl_next.last_symbol = SYMBOL_DASH;
			ctl_next.lamp = 1'b1;
		end
		if (pc != '0) ctl_next.gap_marks = MARK_NONE;

		if ((ctl_next.gap_marks & MARK_SYMBOL) == MARK_NONE && rc != '0 && rc <= sgap) begin
			// The top code bit means six symbols are held; stop shifting there.
			if (!ctl_next.code_bits[CODE_BITS-1])
				ctl_next.code_bits = {ctl_next.code_bits[CODE_BITS-2:0], ctl_next.last_symbol};
			ctl_next.lamp = 1'b0;
			ctl_next.gap_marks = MARK_SYMBOL;
		end else if ((ctl_next.gap_marks & MARK_LETTER) == MARK_NONE && rc >= lgap &&
				rc < wgap) begin
			if (ctl_next.code_bits[CODE_BITS-1])
				res.char_code = CHAR_STAR;
			else
				res.char_code = letter_char(ctl_next.code_bits[TABLE_INDEX_BITS-1:0]);
			res.char_valid = 1'b1;
			ctl_next.code_bits = CODE_START;
			ctl_next.gap_marks = MARK_LETTER;
		end else if ((ctl_next.gap_marks & MARK_WORD) == MARK_NONE && rc >= wgap) begin
			res.char_code = CHAR_SPACE;
			res.char_valid = 1'b1;
			ctl_next.gap_marks = MARK_WORD;
		end

		res.lamp_on = ctl_next.lamp;
	end

	// Count the current press or release.
	always_comb begin
		if (key_pressed) begin
			press_count_next = bump(pc, wgap, cmax);
			release_count_next = '0;
		end else begin
			press_count_next = '0;
			release_count_next = bump(rc, wgap, cmax);
		end
	end

endmodule

// File: hdl/morse_key_decoder_unit.sv
// Morse key decoder: turns key sample beats into lamp state and ASCII characters.
// The result beat of an accepted key beat is in the output register in the next cycle.
// Throughput: one key beat per cycle; the key channel stalls only while a result waits.
// The sample state and the result register update in the same cycle as the accept.
// Reset (arst_n low, asynchronous) restores the default thresholds, clears the press count,
// sets the word gap mark, saturates the release count and empties the output register.
module morse_key_decoder_unit
	import mkd_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input logic       clk,
	input logic       arst_n,
	mkd_cfg_if.sink   cfg,
	mkd_key_if.sink   key_in,
	mkd_res_if.source result_out
);

	cfg_t                  cfg_q;
	logic [COUNT_BITS-1:0] press_count_q;
	logic [COUNT_BITS-1:0] release_count_q;
	ctl_t                  ctl_q;
	logic                  out_valid_q;
	res_t                  out_res_q;

	logic [COUNT_BITS-1:0] press_count_next;
	logic [COUNT_BITS-1:0] release_count_next;
	ctl_t                  ctl_next;
	res_t                  res_next;
	logic                  key_beat;

	// A key beat is taken whenever the output register is free or draining.
	assign key_in.ready = !out_valid_q || result_out.ready;
	assign key_beat = key_in.valid && key_in.ready;
	assign cfg.ready = 1'b1;

	mkd_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.key_pressed       (key_in.key_pressed),
		.cfg               (cfg_q),
		.press_count       (press_count_q),
		.release_count     (release_count_q),
		.ctl               (ctl_q),
		.press_count_next  (press_count_next),
		.release_count_next(release_count_next),
		.ctl_next          (ctl_next),
		.res               (res_next)
	);

	// Threshold registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dit_max_ticks <= DIT_MAX_RESET;
			cfg_q.dah_min_ticks <= DAH_MIN_RESET;
			cfg_q.symbol_gap_max_ticks <= SYMBOL_GAP_MAX_RESET;
			cfg_q.letter_gap_min_ticks <= LETTER_GAP_MIN_RESET;
			cfg_q.word_gap_ticks <= WORD_GAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_DIT_MAX: cfg_q.dit_max_ticks <= cfg.data;
				REG_DAH_MIN: cfg_q.dah_min_ticks <= cfg.data;
				REG_SYMBOL_GAP_MAX: cfg_q.symbol_gap_max_ticks <= cfg.data;
				REG_LETTER_GAP_MIN: cfg_q.letter_gap_min_ticks <= cfg.data;
				REG_WORD_GAP: cfg_q.word_gap_ticks <= cfg.data;
				default: ;
			endcase
		end
	end

	// Decoder state advances once per accepted key beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_count_q <= '0;
			release_count_q <= '1;
			ctl_q.code_bits <= CODE_START;
			ctl_q.last_symbol <= SYMBOL_DOT;
			ctl_q.gap_marks <= MARK_WORD;
			ctl_q.lamp <= 1'b0;
		end else if (key_beat) begin
			press_count_q <= press_count_next;
			release_count_q <= release_count_next;
			ctl_q <= ctl_next;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (key_beat) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (key_beat) begin
			out_res_q <= res_next;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.lamp_on = out_res_q.lamp_on;
	assign result_out.char_valid = out_res_q.char_valid;
	assign result_out.char_code = out_res_q.char_code;

endmodule

// File: hdl/mkd_checker.sv
// Port-level checks of the Morse key decoder and their binding to the top level.
module mkd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       key_valid,
	input logic       key_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_lamp_on,
	input logic       res_char_valid,
	input logic [6:0] res_char_code
);

	// An accepted key beat always shows up as a result beat in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_ready |=> res_valid)
	else $error("accepted key beat produced no result beat");

	// A waiting result blocks the key channel, so no result is overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !key_ready)
	else $error("key beat accepted while a result was stalled");

	// A result beat without a character carries a zero code.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_char_valid |-> res_char_code == 7'd0)
	else $error("character code set without a character");

	// A stalled result beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_lamp_on) &&
			$stable(res_char_valid) && $stable(res_char_code))
	else $error("stalled result beat changed");

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.key_valid     (key_in.valid),
	.key_ready     (key_in.ready),
	.res_valid     (result_out.valid),
	.res_ready     (result_out.ready),
	.res_lamp_on   (result_out.lamp_on),
	.res_char_valid(result_out.char_valid),
	.res_char_code (result_out.char_code)
);
